// File: src/emg_block_average_grip_mode_defines.svh
// Assertion macros for the EMG block averager.
// Taken in by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef EMG_BLOCK_AVERAGE_GRIP_MODE_DEFINES_SVH
`define EMG_BLOCK_AVERAGE_GRIP_MODE_DEFINES_SVH

// Check a property on every rising edge once reset is released.
`define EMGBAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property on the next edge.
`define EMGBAM_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// File: src/emgbam_pkg.sv
// Shared types, constants and helpers for the EMG block averager.
// No dependencies; used by every module of the block.
package emgbam_pkg;

  localparam int WINDOW     = 20;
  localparam int SAMPLE_W   = 10;
  localparam int GAIN_W     = 4;
  localparam int THR_W      = 10;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 15;
  localparam int LEVEL_W    = 18;
  localparam int WIDE_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [GAIN_W-1:0]     GAIN_FULL     = GAIN_W'(10);
  localparam logic [WIDE_W-1:0]     LEVEL_SCALE   = WIDE_W'(10 * WINDOW);
  localparam logic [WIDE_W-1:0]     WINDOW_WIDE   = WIDE_W'(WINDOW);
  localparam logic [CNT_W-1:0]      WINDOW_CNT    = CNT_W'(WINDOW);
  localparam logic [LEVEL_W-1:0]    LEVEL_MAX     = {LEVEL_W{1'b1}};

  localparam logic [GAIN_W-1:0]     GAIN_RST      = GAIN_W'(10);
  localparam logic [THR_W-1:0]      CLOSE_THR_RST = THR_W'(557);
  localparam logic [THR_W-1:0]      LEVEL_THR_RST = THR_W'(702);

  localparam logic [CFG_IDX_W-1:0]  CFG_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_CLOSE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0]  CFG_LEVEL_THR = 2'd2;

  typedef enum logic [1:0] {
    MODE_OPEN   = 2'd0,
    MODE_CLOSED = 2'd1,
    MODE_LEVEL  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [THR_W-1:0]  close_thr;
    logic [THR_W-1:0]  level_thr;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               fresh;
  } lvl_res_t;

  // Threshold in ADC counts moved to the level's scale of 10*WINDOW.
  function automatic logic [WIDE_W-1:0] scale_thr(input logic [THR_W-1:0] thr);
    scale_thr = WIDE_W'(thr) * LEVEL_SCALE;
  endfunction

endpackage

// File: src/emgbam_cfg.sv
// Configuration registers: blend gain and the two mode thresholds.
// Depends on emgbam_pkg.
module emgbam_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [emgbam_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [emgbam_pkg::CFG_DATA_W-1:0]   wr_data,
  output emgbam_pkg::cfg_t                    cfg
);

  emgbam_pkg::cfg_t cfg_r;
  emgbam_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        emgbam_pkg::CFG_GAIN:      cfg_nxt.gain      = wr_data[emgbam_pkg::GAIN_W-1:0];
        emgbam_pkg::CFG_CLOSE_THR: cfg_nxt.close_thr = wr_data[emgbam_pkg::THR_W-1:0];
        emgbam_pkg::CFG_LEVEL_THR: cfg_nxt.level_thr = wr_data[emgbam_pkg::THR_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= emgbam_pkg::GAIN_RST;
      cfg_r.close_thr <= emgbam_pkg::CLOSE_THR_RST;
      cfg_r.level_thr <= emgbam_pkg::LEVEL_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/emgbam_level.sv
// Window accumulator and level blend: sample count, running sum, level.
// Depends on emgbam_pkg and the assertion macro header.
`include "emg_block_average_grip_mode_defines.svh"

module emgbam_level (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [emgbam_pkg::SAMPLE_W-1:0]    sample,
  input  logic [emgbam_pkg::GAIN_W-1:0]      gain,
  output emgbam_pkg::lvl_res_t               res
);

  logic [emgbam_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [emgbam_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [emgbam_pkg::LEVEL_W-1:0] level_r, level_nxt;

  logic                           window_full;
  logic [emgbam_pkg::GAIN_W-1:0]  gain_c;
  logic [emgbam_pkg::GAIN_W-1:0]  gain_rest;
  logic [emgbam_pkg::WIDE_W-1:0]  avg_part;
  logic [emgbam_pkg::WIDE_W-1:0]  new_part;
  logic [emgbam_pkg::WIDE_W-1:0]  blend;

  assign window_full = (count_r >= emgbam_pkg::WINDOW_CNT);

  // Clamp gain to ten tenths.
  assign gain_c    = (gain > emgbam_pkg::GAIN_FULL) ? emgbam_pkg::GAIN_FULL : gain;
  assign gain_rest = emgbam_pkg::GAIN_FULL - gain_c;

  assign avg_part = emgbam_pkg::WIDE_W'(sum_r) * emgbam_pkg::WIDE_W'(gain_c);
  assign new_part = emgbam_pkg::WIDE_W'(sample) * emgbam_pkg::WIDE_W'(gain_rest)
                    * emgbam_pkg::WINDOW_WIDE;
  assign blend    = avg_part + new_part;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    level_nxt = level_r;
    if (step) begin
      if (window_full) begin
        level_nxt = (blend > emgbam_pkg::WIDE_W'(emgbam_pkg::LEVEL_MAX))
                    ? emgbam_pkg::LEVEL_MAX : blend[emgbam_pkg::LEVEL_W-1:0];
        count_nxt = '0;
        sum_nxt   = '0;
      end else begin
        sum_nxt   = sum_r + emgbam_pkg::SUM_W'(sample);
        count_nxt = count_r + emgbam_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      level_r <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      level_r <= level_nxt;
    end
  end

  assign res.level = level_nxt;
  assign res.fresh = step & window_full;

  `EMGBAM_ASSERT(a_count_bound, count_r <= emgbam_pkg::WINDOW_CNT, "sample count past window")
  `EMGBAM_ASSERT_NEXT(a_window_clear, step && window_full, count_r == '0 && sum_r == '0, "no clear")

endmodule

// File: src/emgbam_mode.sv
// Three-state grip mode with threshold hysteresis.
// Depends on emgbam_pkg and the assertion macro header.
`include "emg_block_average_grip_mode_defines.svh"

module emgbam_mode (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [emgbam_pkg::LEVEL_W-1:0]     level,
  input  logic [emgbam_pkg::THR_W-1:0]       close_thr,
  input  logic [emgbam_pkg::THR_W-1:0]       level_thr,
  output logic [1:0]                         grip_mode
);

  emgbam_pkg::mode_t mode_r, mode_nxt;

  logic [emgbam_pkg::WIDE_W-1:0] level_w;
  logic                          above_close;
  logic                          above_level;

  assign level_w     = emgbam_pkg::WIDE_W'(level);
  assign above_close = level_w >= emgbam_pkg::scale_thr(close_thr);
  assign above_level = level_w >= emgbam_pkg::scale_thr(level_thr);

  // Next state: one step per item.
  always_comb begin
    mode_nxt = mode_r;
    if (step) begin
      case (mode_r)
        emgbam_pkg::MODE_CLOSED: begin
          if (!above_close) begin
            mode_nxt = emgbam_pkg::MODE_OPEN;
          end else if (above_level) begin
            mode_nxt = emgbam_pkg::MODE_LEVEL;
          end
        end
        emgbam_pkg::MODE_LEVEL: begin
          if (!above_level) begin
            mode_nxt = emgbam_pkg::MODE_CLOSED;
          end
        end
        default: begin
          mode_nxt = above_close ? emgbam_pkg::MODE_CLOSED : emgbam_pkg::MODE_OPEN;
        end
      endcase
    end
  end

  // Output: mode after this item.
  always_comb begin
    grip_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= emgbam_pkg::MODE_OPEN;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  `EMGBAM_ASSERT_NEXT(a_no_skip, mode_r == emgbam_pkg::MODE_OPEN, mode_r != emgbam_pkg::MODE_LEVEL, "grip mode skipped closed")

endmodule

// File: src/emg_block_average_grip_mode.sv
// A sample is taken into the input register, then into the result register that drives out_*.
// Throughput: one sample per cycle unless out_ready stalls; these registers are two stages.
// in_ready falls only while a result waits and the input register is also full.
// Reset (rst_n low, synchronous): count, sum, level and mode clear to zero (open);
// gain returns to 10, thresholds to 557 and 702. No clearing pass.
// Depends on emgbam_pkg, emgbam_cfg, emgbam_level, emgbam_mode and the macro header.
`include "emg_block_average_grip_mode_defines.svh"

module emg_block_average_grip_mode (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [emgbam_pkg::SAMPLE_W-1:0]    in_emg_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_grip_mode,
  output logic [emgbam_pkg::LEVEL_W-1:0]     out_emg_level,
  output logic                               out_level_fresh,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [emgbam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [emgbam_pkg::CFG_DATA_W-1:0]  cfg_data
);

  emgbam_pkg::cfg_t     cfg;
  emgbam_pkg::lvl_res_t lvl_res;

  logic                               in_valid_r;
  logic [emgbam_pkg::SAMPLE_W-1:0]    in_sample_r;
  logic                               out_valid_r;
  logic [1:0]                         out_mode_r;
  logic [emgbam_pkg::LEVEL_W-1:0]     out_level_r;
  logic                               out_fresh_r;

  logic                               out_free;
  logic                               step;
  logic [1:0]                         mode_next;

  assign cfg_ready = 1'b1;

  emgbam_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  assign step     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  emgbam_level u_level (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .sample (in_sample_r),
    .gain   (cfg.gain),
    .res    (lvl_res)
  );

  emgbam_mode u_mode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .level     (lvl_res.level),
    .close_thr (cfg.close_thr),
    .level_thr (cfg.level_thr),
    .grip_mode (mode_next)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_sample_r <= in_emg_sample;
    end
    if (step) begin
      out_mode_r  <= mode_next;
      out_level_r <= lvl_res.level;
      out_fresh_r <= lvl_res.fresh;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_grip_mode   = out_mode_r;
  assign out_emg_level   = out_level_r;
  assign out_level_fresh = out_fresh_r;

  `EMGBAM_ASSERT_NEXT(a_hold_input, in_valid_r && !out_free, in_valid_r && $stable(in_sample_r), "input beat lost while stalled")

endmodule

// File: verif/tb_emg_block_average_grip_mode.sv
// Testbench for the EMG block averager with grip mode: drives samples and config writes,
// predicts each result beat and checks the beats field by field. Depends on emgbam_pkg.
`timescale 1ns / 1ps

module tb_emg_block_average_grip_mode;
  import emgbam_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    mode_t              mode;
    logic [LEVEL_W-1:0] level;
    logic               fresh;
  } grip_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_emg_sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_grip_mode;
  logic [LEVEL_W-1:0]    out_emg_level;
  logic                  out_level_fresh;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  always #1 clk = ~clk;

  emg_block_average_grip_mode dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_emg_sample   (in_emg_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_grip_mode   (out_grip_mode),
    .out_emg_level   (out_emg_level),
    .out_level_fresh (out_level_fresh),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Shadow copy of the block's registers and state.
  logic [GAIN_W-1:0]  gain_r;
  logic [THR_W-1:0]   close_thr_r;
  logic [THR_W-1:0]   level_thr_r;
  int unsigned        win_count;
  logic [SUM_W-1:0]   win_sum;
  logic [LEVEL_W-1:0] level_r;
  mode_t              mode_r;

  grip_beat_t pending_q[$];
  int         errors = 0;
  int         n_sent = 0;
  int         n_fresh = 0;
  int         n_phases = 0;
  int         mode_hits[3] = '{0, 0, 0};
  bit         steady = 1'b0;

  function automatic grip_beat_t predict_grip(input logic [SAMPLE_W-1:0] s);
    grip_beat_t  r;
    int unsigned g;
    int unsigned blend;
    int unsigned close_lvl;
    int unsigned level_lvl;
    close_lvl = 32'(close_thr_r) * 32'(LEVEL_SCALE);
    level_lvl = 32'(level_thr_r) * 32'(LEVEL_SCALE);
    r.fresh = 1'b0;
    if (win_count >= WINDOW) begin
      g = (gain_r > GAIN_FULL) ? 32'(GAIN_FULL) : 32'(gain_r);
      blend = 32'(win_sum) * g + 32'(s) * (32'(GAIN_FULL) - g) * 32'(WINDOW);
      level_r = (blend > 32'(LEVEL_MAX)) ? LEVEL_MAX : blend[LEVEL_W-1:0];
      win_count = 0;
      win_sum = '0;
      r.fresh = 1'b1;
    end else begin
      win_sum = win_sum + SUM_W'(s);
      win_count++;
    end
    // Hysteresis: one mode step per sample.
    case (mode_r)
      MODE_CLOSED: begin
        if (level_r < close_lvl) mode_r = MODE_OPEN;
        else if (level_r >= level_lvl) mode_r = MODE_LEVEL;
      end
      MODE_LEVEL: begin
        if (level_r < level_lvl) mode_r = MODE_CLOSED;
      end
      default: begin
        mode_r = (level_r >= close_lvl) ? MODE_CLOSED : MODE_OPEN;
      end
    endcase
    r.mode = mode_r;
    r.level = level_r;
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    grip_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with no sample pending");
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_grip_mode !== want.mode) begin
          $error("grip_mode: expected %0d, got %0d", want.mode, out_grip_mode);
          errors++;
        end
        if (out_emg_level !== want.level) begin
          $error("emg_level: expected %0d, got %0d", want.level, out_emg_level);
          errors++;
        end
        if (out_level_fresh !== want.fresh) begin
          $error("level_fresh: expected %0d, got %0d", want.fresh, out_level_fresh);
          errors++;
        end
        if (want.fresh) n_fresh++;
        mode_hits[want.mode]++;
      end
    end
  end

  // Result side: stall in bursts, drop stalls once steady is set.
  initial begin : result_backpressure
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Leaves in_valid high after the beat so back-to-back samples stream, but for random gaps before steady is set.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    in_valid      <= 1'b1;
    in_emg_sample <= s;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(predict_grip(s));
    n_sent++;
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GAIN:      gain_r = data[GAIN_W-1:0];
      CFG_CLOSE_THR: close_thr_r = data[THR_W-1:0];
      CFG_LEVEL_THR: level_thr_r = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] gain, input logic [THR_W-1:0] close_thr,
                              input logic [THR_W-1:0] level_thr);
    drain_results();
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_CLOSE_THR, close_thr);
    write_reg(CFG_LEVEL_THR, level_thr);
    cfg_valid <= 1'b0;
    n_phases++;
  endtask

  // Windows of samples clustered around a base, mostly near a threshold, plus some noise.
  task automatic run_windows(input int n_items);
    int base;
    int spread;
    int v;
    for (int i = 0; i < n_items; i++) begin
      if (i % (WINDOW + 1) == 0) begin
        case ($urandom_range(0, 2))
          0: base = int'(close_thr_r);
          1: base = int'(level_thr_r);
          default: base = int'($urandom_range(0, 1023));
        endcase
        spread = int'($urandom_range(0, 120));
      end
      if ($urandom_range(0, 9) < 8) begin
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end else begin
        v = int'($urandom_range(0, 1023));
      end
      send_sample(v[SAMPLE_W-1:0]);
    end
  endtask

  task automatic test_directed_extremes();
    logic [SAMPLE_W-1:0] lead [6] = '{10'd0, 10'h3FF, 10'h155, 10'h2AA, 10'd1, 10'h200};
    foreach (lead[i]) send_sample(lead[i]);
    repeat (WINDOW - 6) send_sample(10'h3FF);
    // gain above ten must weigh the window average fully
    apply_config(10'd13, CLOSE_THR_RST, LEVEL_THR_RST);
    send_sample(10'd0);
    send_sample(10'h3FF);
    send_sample(10'd0);
    send_sample(10'h3FF);
  endtask

  task automatic test_gain_extremes();
    apply_config(10'd0, 10'd300, 10'd700);
    run_windows(63);
    apply_config(10'h3FF, 10'd300, 10'd700);
    run_windows(63);
  endtask

  task automatic test_threshold_extremes();
    apply_config(CFG_DATA_W'($urandom_range(0, 10)), 10'd0, 10'h3FF);
    run_windows(63);
    apply_config(10'd10, 10'h3FF, 10'd0);
    run_windows(63);
    apply_config(10'd5, 10'd0, 10'd0);
    run_windows(63);
  endtask

  task automatic test_random_config();
    repeat (3) begin
      apply_config(CFG_DATA_W'($urandom_range(0, 1023)), THR_W'($urandom_range(0, 1023)),
                   THR_W'($urandom_range(0, 1023)));
      run_windows(42);
    end
  endtask

  task automatic test_unused_index();
    drain_results();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 1023)));
    cfg_valid <= 1'b0;
    run_windows(21);
  endtask

  task automatic test_steady_stream();
    apply_config(CFG_DATA_W'($urandom_range(0, 10)), THR_W'($urandom_range(200, 500)),
                 THR_W'($urandom_range(500, 900)));
    steady = 1'b1;
    run_windows(84);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_emg_sample <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_GAIN;
    cfg_data      <= '0;
    gain_r      = GAIN_RST;
    close_thr_r = CLOSE_THR_RST;
    level_thr_r = LEVEL_THR_RST;
    win_count   = 0;
    win_sum     = '0;
    level_r     = '0;
    mode_r      = MODE_OPEN;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_gain_extremes();
    test_threshold_extremes();
    test_random_config();
    test_unused_index();
    test_steady_stream();

    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && pending_q.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d result beats never arrived", pending_q.size());
      errors++;
    end

    $display("summary: %0d samples over %0d config phases, %0d level updates",
             n_sent, n_phases, n_fresh);
    $display("summary: beats per mode open/closed/leveling %0d/%0d/%0d",
             mode_hits[0], mode_hits[1], mode_hits[2]);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/emgbam_pkg.sv
src/emgbam_cfg.sv
src/emgbam_level.sv
src/emgbam_mode.sv
src/emg_block_average_grip_mode.sv
verif/tb_emg_block_average_grip_mode.sv
